/* rtl/core/pvlc_pkg.sv */
// ----------------------------------------------------------------------------
// pvlc_pkg : shared types for the palette variant cache
// Holds the packed variant key and the store control word.
// ----------------------------------------------------------------------------
package pvlc_pkg;

  // Action codes carried on the input channel
  localparam logic ACT_LOOKUP     = 1'b0;
  localparam logic ACT_INVALIDATE = 1'b1;

  // Width of the use counter and of each stamp
  localparam int unsigned STAMP_W = 32;
  // Width of the capacity register
  localparam int unsigned CAP_W   = 4;
  // Width of the slot field in a result
  localparam int unsigned SLOT_W  = 3;
  // Shading alpha that turns shading on
  localparam logic [7:0]  SHADE_ON_ALPHA = 8'd255;

  // Variant key beside the palette hash: shading packs red, green, blue,
  // alpha from the low byte up; mode is semi_trans over blend_mode
  typedef struct packed {
    logic [31:0] shading;
    logic [2:0]  mode;
  } key_t;

  // Update request from the top level into the slot store
  typedef struct packed {
    logic clr;    // drop every valid bit
    logic fill;   // write key, hash and stamp, set valid
    logic touch;  // refresh the stamp only
  } store_ctl_t;

endpackage

/* rtl/core/pvlc_slot_store.sv */
// ----------------------------------------------------------------------------
// pvlc_slot_store : slot registers with parallel tag match
// Keeps valid bits, tags and stamps for each slot and flags every slot whose
// valid tag equals the presented key.
// ----------------------------------------------------------------------------
module pvlc_slot_store #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned TAG_W   = 32,
  parameter int unsigned IDX_W   = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pvlc_pkg::store_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]             wr_idx_i,
  input  logic [TAG_W-1:0]             key_hash_i,
  input  pvlc_pkg::key_t               key_i,
  input  logic [pvlc_pkg::STAMP_W-1:0] stamp_i,
  output logic [ENTRIES-1:0]           valid_o,
  output logic [ENTRIES-1:0]           match_o,
  output logic [pvlc_pkg::STAMP_W-1:0] stamps_o [ENTRIES]
);

  logic [ENTRIES-1:0]           valid_q;
  logic [TAG_W-1:0]             hash_q  [ENTRIES];
  pvlc_pkg::key_t               key_q   [ENTRIES];
  logic [pvlc_pkg::STAMP_W-1:0] stamp_q [ENTRIES];

  // Clear all on invalidate, set the filled slot's bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clr) begin
      valid_q <= '0;
    end else if (ctl_i.fill) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // Write tag and stamp of the target slot
  always_ff @(posedge clk_i) begin
    if (ctl_i.fill) begin
      hash_q[wr_idx_i] <= key_hash_i;
      key_q[wr_idx_i]  <= key_i;
    end
    if (ctl_i.fill || ctl_i.touch) begin
      stamp_q[wr_idx_i] <= stamp_i;
    end
  end

  // Compare every slot against the key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_o[i]  = valid_q[i] && (hash_q[i] == key_hash_i) && (key_q[i] == key_i);
      stamps_o[i] = stamp_q[i];
    end
  end

  assign valid_o = valid_q;

endmodule

/* rtl/core/pvlc_victim_sel.sv */
// ----------------------------------------------------------------------------
// pvlc_victim_sel : replacement slot selection
// Counts valid slots, finds the lowest free slot and the valid slot with the
// oldest stamp (lowest index on a tie), and resolves the lowest matching slot.
// ----------------------------------------------------------------------------
module pvlc_victim_sel #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned IDX_W   = 3,
  parameter int unsigned CNT_W   = 4
) (
  input  logic [ENTRIES-1:0]           valid_i,
  input  logic [ENTRIES-1:0]           match_i,
  input  logic [pvlc_pkg::STAMP_W-1:0] stamps_i [ENTRIES],
  output logic [CNT_W-1:0]             nvalid_o,
  output logic                         hit_o,
  output logic [IDX_W-1:0]             hit_idx_o,
  output logic [IDX_W-1:0]             free_idx_o,
  output logic [IDX_W-1:0]             old_idx_o
);

  logic [pvlc_pkg::STAMP_W-1:0] best_stamp;
  logic                         found;

  // Count valid slots
  always_comb begin
    nvalid_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      nvalid_o = nvalid_o + CNT_W'(valid_i[i]);
    end
  end

  // Pick the lowest matching and the lowest free slot
  always_comb begin
    hit_o      = |match_i;
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        hit_idx_o = IDX_W'(i);
      end
      if (!valid_i[i]) begin
        free_idx_o = IDX_W'(i);
      end
    end
  end

  // Scan for the oldest valid stamp; strict less keeps the lowest on a tie
  always_comb begin
    found      = 1'b0;
    best_stamp = '0;
    old_idx_o  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_i[i] && (!found || (stamps_i[i] < best_stamp))) begin
        found      = 1'b1;
        best_stamp = stamps_i[i];
        old_idx_o  = IDX_W'(i);
      end
    end
  end

endmodule

/* rtl/core/palette_variant_lru_cache.sv */
// ----------------------------------------------------------------------------
// palette_variant_lru_cache : fully associative LRU cache of texture variants
// Looks up a palette/shading/mode key, refreshes or fills a slot, reports it.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result side does not stall, and returns
// one result beat per input beat. The beat is captured in an input register,
// then the tag compare over all slots, the oldest-stamp scan and the slot
// update happen together in the cycle that loads the result register, which
// presents the result beat. Back-pressure on the result side stalls the input
// register only when the result register is still full. Capacity (clamped to
// 1..ENTRIES) should change only while idle and together with an invalidate
// beat.
module palette_variant_lru_cache #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned HASH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] palette_hash_i,
  input  logic [7:0]  shade_red_i,
  input  logic [7:0]  shade_green_i,
  input  logic [7:0]  shade_blue_i,
  input  logic [7:0]  shade_alpha_i,
  input  logic        semi_trans_i,
  input  logic [1:0]  blend_mode_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [2:0]  slot_o,
  output logic        evicted_o
);

  localparam int unsigned TAG_W = (HASH_BITS < 32) ? HASH_BITS : 32;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W =
      (CNT_W > pvlc_pkg::CAP_W) ? CNT_W : pvlc_pkg::CAP_W;

  // Capacity register
  logic [pvlc_pkg::CAP_W-1:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= pvlc_pkg::CAP_W'(8);
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Input register
  logic        item_valid_q;
  logic        action_q;
  logic [31:0] hash_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        semi_q;
  logic [1:0]  blend_q;
  logic        out_valid_q;
  logic        proc;

  assign proc       = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      hash_q   <= palette_hash_i;
      red_q    <= shade_red_i;
      green_q  <= shade_green_i;
      blue_q   <= shade_blue_i;
      alpha_q  <= shade_alpha_i;
      semi_q   <= semi_trans_i;
      blend_q  <= blend_mode_i;
    end
  end

  // Build the key; drop the tint unless shading is on
  pvlc_pkg::key_t   key;
  logic [TAG_W-1:0] key_hash;

  always_comb begin
    key_hash = hash_q[TAG_W-1:0];
    key.mode = {semi_q, blend_q};
    if (alpha_q == pvlc_pkg::SHADE_ON_ALPHA) begin
      key.shading = {pvlc_pkg::SHADE_ON_ALPHA, blue_q, green_q, red_q};
    end else begin
      key.shading = '0;
    end
  end

  // Use counter
  logic [pvlc_pkg::STAMP_W-1:0] use_count_q, use_count_d;

  always_comb begin
    use_count_d = use_count_q;
    if (proc && (action_q == pvlc_pkg::ACT_LOOKUP)) begin
      use_count_d = use_count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_count_q <= '0;
    end else begin
      use_count_q <= use_count_d;
    end
  end

  // Slot store and selection
  pvlc_pkg::store_ctl_t         ctl;
  logic [IDX_W-1:0]             target;
  logic [ENTRIES-1:0]           valid;
  logic [ENTRIES-1:0]           match;
  logic [pvlc_pkg::STAMP_W-1:0] stamps [ENTRIES];
  logic [CNT_W-1:0]             nvalid;
  logic                         hit;
  logic [IDX_W-1:0]             hit_idx, free_idx, old_idx;

  pvlc_slot_store #(
    .ENTRIES (ENTRIES),
    .TAG_W   (TAG_W),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .wr_idx_i   (target),
    .key_hash_i (key_hash),
    .key_i      (key),
    .stamp_i    (use_count_d),
    .valid_o    (valid),
    .match_o    (match),
    .stamps_o   (stamps)
  );

  pvlc_victim_sel #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_victim (
    .valid_i    (valid),
    .match_i    (match),
    .stamps_i   (stamps),
    .nvalid_o   (nvalid),
    .hit_o      (hit),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .old_idx_o  (old_idx)
  );

  // Clamp capacity to 1..ENTRIES and decide hit, fill or evict
  logic [CMP_W-1:0] eff_cap;
  logic             full;
  logic             res_hit, res_evict;

  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity_q);
    end
    full = CMP_W'(nvalid) >= eff_cap;

    ctl       = '0;
    target    = '0;
    res_hit   = 1'b0;
    res_evict = 1'b0;
    if (action_q == pvlc_pkg::ACT_INVALIDATE) begin
      ctl.clr = proc;
    end else if (hit) begin
      res_hit   = 1'b1;
      target    = hit_idx;
      ctl.touch = proc;
    end else begin
      res_evict = full;
      target    = full ? old_idx : free_idx;
      ctl.fill  = proc;
    end
  end

  // Result register
  logic                        hit_q, evicted_q;
  logic [pvlc_pkg::SLOT_W-1:0] slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      hit_q     <= res_hit;
      evicted_q <= res_evict;
      slot_q    <= pvlc_pkg::SLOT_W'(target);
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign slot_o      = slot_q;
  assign evicted_o   = evicted_q;

endmodule
